### rtl/iis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iis_pkg
// Shared widths and the decoded transaction type of the in-order issue
// scoreboard.
// ----------------------------------------------------------------------------
package iis_pkg;

  localparam int NUM_REGS    = 32;
  localparam int REG_IDX_W   = 5;
  localparam int XLEN        = 64;
  localparam int SPEC_W      = 6;
  localparam int QSPEC_W     = 3 * SPEC_W;
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 208;

  // One input transaction, unpacked from the stream word.
  typedef struct packed {
    logic                 flush;
    logic                 wb_write;
    logic [REG_IDX_W-1:0] wb_reg;
    logic [XLEN-1:0]      wb_value;
    logic                 exe_dest_valid;
    logic [REG_IDX_W-1:0] exe_dest_reg;
    logic                 dec_valid;
    logic [SPEC_W-1:0]    src1_spec;
    logic [SPEC_W-1:0]    src2_spec;
    logic [SPEC_W-1:0]    dest_spec;
    logic [XLEN-1:0]      inst_tag;
  } iis_item_t;

endpackage
`default_nettype wire

### rtl/iis_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iis_front
// Input side: unpacks each stream transaction into its fields and holds it in
// a two-entry queue until the execution core takes it.
// ----------------------------------------------------------------------------
module iis_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [iis_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                item_valid,
  output iis_pkg::iis_item_t                  item,
  input  wire logic                           item_pop
);
  import iis_pkg::*;

  iis_item_t  buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  iis_item_t  unpacked;

  always_comb begin
    unpacked.flush          = in_tdata[0];
    unpacked.wb_write       = in_tdata[1];
    unpacked.wb_reg         = in_tdata[6:2];
    unpacked.wb_value       = in_tdata[70:7];
    unpacked.exe_dest_valid = in_tdata[71];
    unpacked.exe_dest_reg   = in_tdata[76:72];
    unpacked.dec_valid      = in_tdata[77];
    unpacked.src1_spec      = in_tdata[83:78];
    unpacked.src2_spec      = in_tdata[89:84];
    unpacked.dest_spec      = in_tdata[95:90];
    unpacked.inst_tag       = in_tdata[159:96];
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= unpacked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (item_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, item_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/iis_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iis_core
// Execution core: register file, scoreboard valid bits and the instruction
// queue, stepped once per transaction in three phases, with a registered
// result output.
// ----------------------------------------------------------------------------
module iis_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            item_valid,
  input  wire iis_pkg::iis_item_t              item,
  output logic                                 item_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [iis_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import iis_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW:0]   DEPTH_W  = (QW+1)'(QUEUE_DEPTH);
  localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_UPD, S_OPER, S_ISSUE} state_t;

  state_t              state_r;
  logic [QW-1:0]       head_r;
  logic [CW-1:0]       count_r;
  logic [NUM_REGS-1:0] ready_r;
  logic [NUM_REGS-1:0] written_r;

  // Storage without reset.
  logic [XLEN-1:0]     rf_mem    [NUM_REGS];
  logic [QSPEC_W-1:0]  q_spec_mem[QUEUE_DEPTH];
  logic [XLEN-1:0]     q_tag_mem [QUEUE_DEPTH];

  // Phase registers.
  logic                 flush_r;
  logic                 acc_r;
  logic                 exe_v_r;
  logic [REG_IDX_W-1:0] exe_reg_r;
  logic                 hd_valid_r;
  logic                 byp_r;
  logic [QSPEC_W-1:0]   byp_spec_r;
  logic [XLEN-1:0]      byp_tag_r;
  logic [QSPEC_W-1:0]   q_rd_spec_r;
  logic [XLEN-1:0]      q_rd_tag_r;
  logic                 rdy_r;
  logic                 use1_r;
  logic                 use2_r;
  logic                 wr1_r;
  logic                 wr2_r;
  logic [SPEC_W-1:0]    dest_r;
  logic [XLEN-1:0]      tag_r;
  logic [XLEN-1:0]      rf_rd1_r;
  logic [XLEN-1:0]      rf_rd2_r;
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  logic                 push;
  logic [QW:0]          tail_sum;
  logic [QW:0]          tail_fix;
  logic [QW-1:0]        tail_idx;
  logic [QSPEC_W-1:0]   head_spec;
  logic [XLEN-1:0]      head_tag;
  logic [SPEC_W-1:0]    s1;
  logic [SPEC_W-1:0]    s2;
  logic                 r1;
  logic                 r2;
  logic                 out_free;
  logic [XLEN-1:0]      val1;
  logic [XLEN-1:0]      val2;

  assign item_pop = (state_r == S_UPD) && item_valid;
  assign push     = !item.flush && item.dec_valid && (count_r != DEPTH_C);
  assign tail_sum = {1'b0, head_r} + (QW+1)'(count_r);
  assign tail_fix = (tail_sum >= DEPTH_W) ? (tail_sum - DEPTH_W) : tail_sum;
  assign tail_idx = tail_fix[QW-1:0];

  assign head_spec = byp_r ? byp_spec_r : q_rd_spec_r;
  assign head_tag  = byp_r ? byp_tag_r  : q_rd_tag_r;
  assign s1        = head_spec[SPEC_W-1:0];
  assign s2        = head_spec[2*SPEC_W-1:SPEC_W];

  // A used source is ready when the execute stage is not about to write it
  // and its scoreboard bit is set.
  assign r1 = !s1[5] ||
              (!(exe_v_r && (exe_reg_r == s1[4:0])) && ready_r[s1[4:0]]);
  assign r2 = !s2[5] ||
              (!(exe_v_r && (exe_reg_r == s2[4:0])) && ready_r[s2[4:0]]);

  // Registers never written read as zero; the register file itself has no reset.
  assign val1 = (rdy_r && use1_r && wr1_r) ? rf_rd1_r : '0;
  assign val2 = (rdy_r && use2_r && wr2_r) ? rf_rd2_r : '0;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (item_pop) begin
      if (push) begin
        q_spec_mem[tail_idx] <= {item.dest_spec, item.src2_spec, item.src1_spec};
        q_tag_mem[tail_idx]  <= item.inst_tag;
      end
      q_rd_spec_r <= q_spec_mem[head_r];
      q_rd_tag_r  <= q_tag_mem[head_r];
      if (item.wb_write) begin
        rf_mem[item.wb_reg] <= (item.wb_reg == '0) ? '0 : item.wb_value;
      end
    end
    if (state_r == S_OPER) begin
      rf_rd1_r <= rf_mem[s1[4:0]];
      rf_rd2_r <= rf_mem[s2[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_UPD;
      head_r      <= '0;
      count_r     <= '0;
      ready_r     <= '1;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_UPD: begin
          if (item_valid) begin
            flush_r    <= item.flush;
            acc_r      <= push;
            exe_v_r    <= item.exe_dest_valid;
            exe_reg_r  <= item.exe_dest_reg;
            hd_valid_r <= !item.flush && ((count_r != '0) || push);
            byp_r      <= (count_r == '0) && push;
            byp_spec_r <= {item.dest_spec, item.src2_spec, item.src1_spec};
            byp_tag_r  <= item.inst_tag;
            if (item.wb_write) begin
              written_r[item.wb_reg] <= 1'b1;
            end
            if (item.flush) begin
              head_r  <= '0;
              count_r <= '0;
              ready_r <= '1;
            end else begin
              if (push) begin
                count_r <= count_r + CW'(1);
              end
              if (item.wb_write) begin
                ready_r[item.wb_reg] <= 1'b1;
              end
            end
            state_r <= S_OPER;
          end
        end
        S_OPER: begin
          rdy_r   <= hd_valid_r && r1 && r2;
          use1_r  <= s1[5];
          use2_r  <= s2[5];
          wr1_r   <= written_r[s1[4:0]];
          wr2_r   <= written_r[s2[4:0]];
          dest_r  <= head_spec[QSPEC_W-1:2*SPEC_W];
          tag_r   <= head_tag;
          state_r <= S_ISSUE;
        end
        S_ISSUE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'd0, flush_r,
                            (rdy_r ? tag_r : {XLEN{1'b0}}),
                            (rdy_r ? dest_r : {SPEC_W{1'b0}}),
                            val2, val1, rdy_r, acc_r};
            if (rdy_r) begin
              head_r  <= (head_r == LAST_IDX) ? '0 : head_r + QW'(1);
              count_r <= count_r - CW'(1);
              // Register zero is never marked busy.
              if (dest_r[5] && (dest_r[4:0] != '0)) begin
                ready_r[dest_r[4:0]] <= 1'b0;
              end
            end
            state_r <= S_UPD;
          end
        end
        default: begin
          state_r <= S_UPD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/inorder_issue_scoreboard.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inorder_issue_scoreboard
// In-order single-issue stage with a register scoreboard, stepped once per
// input transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one clock step of an in-order issue stage and
// produces exactly one result transaction. A step with flush set marks every
// register valid, applies the writeback, empties the instruction queue and
// reports flush_downstream. Otherwise the step pushes the offered instruction
// if the queue has room, applies the writeback (register zero always reads
// zero), and issues the queue head when both of its used sources are neither
// targeted by the execute stage nor marked busy; a used nonzero destination
// is then marked busy. A transaction passes through three steps in the core:
// it updates the queue, register file and valid bits, reads the head operands
// from the register file, and loads the result register once it is free; the
// core takes no new transaction before that. A two-entry input queue lets the
// upstream side keep sending while the core works, and the result register
// holds a finished result until it is taken. Queue contents are not cleared
// at reset; only entries already pushed are ever used.
// ----------------------------------------------------------------------------
module inorder_issue_scoreboard #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // Fields from bit 0 up: flush, wb_write, wb_reg[5], wb_value[64],
  // exe_dest_valid, exe_dest_reg[5], dec_valid, src1_spec[6], src2_spec[6],
  // dest_spec[6], inst_tag[64].
  input  wire logic [159:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // Fields from bit 0 up: dec_accept, issue_valid, issue_src1_value[64],
  // issue_src2_value[64], issue_dest_spec[6], issue_tag[64],
  // flush_downstream, then seven zero bits.
  output logic [207:0]      out_tdata
);
  import iis_pkg::*;

  logic      item_valid;
  iis_item_t item;
  logic      item_pop;

  // Front end: unpacking and buffering of input transactions.
  iis_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // Back end: scoreboard, register file, instruction queue and result.
  iis_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
